FILE: design/link_session_loss_monitor_defines.svh
`ifndef LINK_SESSION_LOSS_MONITOR_DEFINES_SVH
`define LINK_SESSION_LOSS_MONITOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define LSLM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define LSLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lslm_pkg.sv
`timescale 1ns / 1ps

package lslm_pkg;

  // beat kinds carried in s_tuser
  typedef enum logic [1:0] {
    CMD_ACK    = 2'd0,
    CMD_SENSOR = 2'd1,
    CMD_INIT   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_LISTENER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SESSION  = 2'd1;

  localparam int CMD_W     = 2;
  localparam int SESSION_W = 16;
  localparam int SEQ_W     = 16;
  localparam int LINK_W    = 6;
  localparam int BIN_SEL_W = 4;
  localparam int CNT_W     = 32;

  localparam logic [SESSION_W-1:0] OWN_SESSION_RST = 16'd1;

  localparam int HIST_BINS_DEF = 16;
  localparam int DRIVERS_DEF   = 6;

  // packed beat widths
  localparam int IN_USED_W   = 4 * SEQ_W + LINK_W + BIN_SEL_W;
  localparam int IN_DATA_W   = 80;
  localparam int IN_PAD_W    = IN_DATA_W - IN_USED_W;
  localparam int OUT_USED_W  = 3 + SESSION_W + LINK_W + 6 * CNT_W + SEQ_W;
  localparam int OUT_DATA_W  = 240;
  localparam int OUT_PAD_W   = OUT_DATA_W - OUT_USED_W;

  // result field offsets in m_tdata
  localparam int O_ACC   = 0;
  localparam int O_SESS  = 1;
  localparam int O_VALID = O_SESS + SESSION_W;
  localparam int O_ACK   = O_VALID + 1;

endpackage

FILE: design/link_session_loss_monitor.sv
`timescale 1ns / 1ps

// Receive-side link monitor. Each input beat carries one event in s_tuser (ack header,
// sensor header, init sent, or a plain statistics read) and produces exactly one result
// beat holding the session, handshake flags and loss statistics after that event, plus
// the two histogram counts at bin_select (all ones when bin_select is past the last bin).
// One beat is taken every clock cycle unless the result stalls; each beat passes one input
// register and then one result register, with a single pass of logic in between. The input
// register lets one more beat in while a result waits on m_tready.
// Each histogram bin has its own incrementer, so an ack or a reboot clears all bins in
// that same cycle. Configuration writes re-initialise the whole state and must only be
// issued while no beat is in flight; a write of zero to own_session keeps the old
// session but still re-initialises the state.
module link_session_loss_monitor #(
  parameter int HIST_BINS = lslm_pkg::HIST_BINS_DEF,
  parameter int DRIVERS   = lslm_pkg::DRIVERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // slave side
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // pkt_session, pkt_sensor_seq, pkt_cmd_loss, pkt_last_cmd_seq, pkt_link_mask,
  // bin_select, zero fill
  input  logic [lslm_pkg::IN_DATA_W-1:0]  s_tdata,
  // command
  input  logic [lslm_pkg::CMD_W-1:0]      s_tuser,
  // master side
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // accepted, session_value, session_valid, ack_seen, link_mask, sensors_received,
  // sensors_expected, sensors_lost, commands_lost, last_cmd_seq_seen,
  // sensor_bin_count, cmd_bin_count, zero fill
  output logic [lslm_pkg::OUT_DATA_W-1:0] m_tdata,
  // configuration
  input  logic                            cfg_we,
  input  logic [lslm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lslm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lslm_pkg::*;

  localparam int BinW  = $clog2(HIST_BINS);
  localparam int MaskW = (DRIVERS < LINK_W) ? DRIVERS : LINK_W;

  // configuration registers
  logic                 listen_en;
  logic [SESSION_W-1:0] own_session;
  logic                 cfg_do;
  logic                 cfg_lm_next;
  logic [SESSION_W-1:0] cfg_os_next;

  // input register
  logic                 in_v;
  cmd_t                 in_cmd;
  logic [SESSION_W-1:0] in_sess;
  logic [SEQ_W-1:0]     in_seq;
  logic [SEQ_W-1:0]     in_loss;
  logic [SEQ_W-1:0]     in_lcmd;
  logic [LINK_W-1:0]    in_mask;
  logic [BIN_SEL_W-1:0] in_bin;

  // monitor state
  logic                 session_known;
  logic [SESSION_W-1:0] session_reg;
  logic                 init_flag;
  logic                 ack_flag;
  logic                 first_flag;
  logic [SEQ_W-1:0]     prev_seq;
  logic [SEQ_W-1:0]     prev_cmd_loss;
  logic [MaskW-1:0]     conn_mask;
  logic [SEQ_W-1:0]     last_cmd;
  logic [CNT_W-1:0]     cnt_rx;
  logic [CNT_W-1:0]     cnt_exp;
  logic [CNT_W-1:0]     cnt_lost;
  logic [CNT_W-1:0]     cnt_cmd;
  logic [CNT_W-1:0]     hist_s [HIST_BINS];
  logic [CNT_W-1:0]     hist_c [HIST_BINS];

  // next values for one beat
  logic                 session_known_next;
  logic [SESSION_W-1:0] session_reg_next;
  logic                 init_flag_next;
  logic                 ack_flag_next;
  logic                 first_flag_next;
  logic [SEQ_W-1:0]     prev_seq_next;
  logic [SEQ_W-1:0]     prev_cmd_loss_next;
  logic [MaskW-1:0]     conn_mask_next;
  logic [SEQ_W-1:0]     last_cmd_next;
  logic [CNT_W-1:0]     cnt_rx_next;
  logic [CNT_W-1:0]     cnt_exp_next;
  logic [CNT_W-1:0]     cnt_lost_next;
  logic [CNT_W-1:0]     cnt_cmd_next;
  logic [CNT_W-1:0]     hist_s_next [HIST_BINS];
  logic [CNT_W-1:0]     hist_c_next [HIST_BINS];

  logic                 acc;
  logic                 clr;
  logic                 upd;
  logic                 ff_eff;
  logic [SEQ_W-1:0]     ps_eff;
  logic [SEQ_W-1:0]     span;
  logic [SEQ_W-1:0]     sgap;
  logic [SEQ_W-1:0]     cgap;
  logic [SEQ_W-1:0]     sbin_raw;
  logic [SEQ_W-1:0]     cbin_raw;
  logic [BinW-1:0]      sbin;
  logic [BinW-1:0]      cbin;
  logic                 s_hit;
  logic                 c_hit;
  logic [BinW-1:0]      sel;
  logic                 sel_ok;
  logic [CNT_W-1:0]     sel_s;
  logic [CNT_W-1:0]     sel_c;
  logic [OUT_DATA_W-1:0] out_data;

  // handshake: the input register drains whenever the result register is free
  logic adv;
  logic fire;
  assign adv      = !m_tvalid || m_tready;
  assign fire     = in_v && adv;
  assign s_tready = !in_v || adv;

  // config decode: a zero session write keeps the old session but still re-initialises
  always_comb begin
    cfg_do      = 1'b0;
    cfg_lm_next = listen_en;
    cfg_os_next = own_session;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_LISTENER: begin
          cfg_do      = 1'b1;
          cfg_lm_next = cfg_data[0];
        end
        REG_SESSION: begin
          cfg_do = 1'b1;
          if (cfg_data[SESSION_W-1:0] != '0) begin
            cfg_os_next = cfg_data[SESSION_W-1:0];
          end
        end
        default: begin
          cfg_do = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_en   <= 1'b0;
      own_session <= OWN_SESSION_RST;
    end else if (cfg_do) begin
      listen_en   <= cfg_lm_next;
      own_session <= cfg_os_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= cmd_t'(s_tuser);
      in_sess <= s_tdata[15:0];
      in_seq  <= s_tdata[31:16];
      in_loss <= s_tdata[47:32];
      in_lcmd <= s_tdata[63:48];
      in_mask <= s_tdata[69:64];
      in_bin  <= s_tdata[73:70];
    end
  end

  // handshake and session checks
  always_comb begin
    session_known_next = session_known;
    session_reg_next   = session_reg;
    init_flag_next     = init_flag;
    ack_flag_next      = ack_flag;
    conn_mask_next     = conn_mask;
    acc                = 1'b0;
    clr                = 1'b0;
    upd                = 1'b0;
    unique case (in_cmd)
      CMD_ACK: begin
        if (listen_en || (init_flag && !ack_flag)) begin
          if (listen_en) begin
            session_reg_next   = in_sess;
            session_known_next = 1'b1;
          end
          if (in_sess == session_reg_next) begin
            clr            = 1'b1;
            conn_mask_next = in_mask[MaskW-1:0];
            ack_flag_next  = 1'b1;
            acc            = 1'b1;
          end
        end
      end
      CMD_SENSOR: begin
        if (listen_en || (init_flag && ack_flag)) begin
          if (listen_en) begin
            if (!session_known) begin
              session_reg_next   = in_sess;
              session_known_next = 1'b1;
            end else if (session_reg != '0 && in_sess == '0) begin
              // board rebooted: restart the statistics
              session_reg_next = '0;
              clr              = 1'b1;
            end
          end
          if (session_known_next && in_sess == session_reg_next) begin
            upd = 1'b1;
            acc = 1'b1;
          end
        end
      end
      CMD_INIT: begin
        init_flag_next = 1'b1;
      end
      CMD_READ: begin
        acc = 1'b0;
      end
      default: begin
        acc = 1'b0;
      end
    endcase
  end

  // sequence gaps, all modulo 2^16
  always_comb begin
    ff_eff = clr ? 1'b0 : first_flag;
    ps_eff = clr ? '0 : prev_seq;
    span   = ff_eff ? (in_seq - ps_eff) : SEQ_W'(1);
    sgap   = span - SEQ_W'(1);
    cgap   = ff_eff ? (in_loss - prev_cmd_loss) : '0;

    sbin_raw = sgap - SEQ_W'(1);
    cbin_raw = cgap - SEQ_W'(1);
    sbin = (sbin_raw >= SEQ_W'(HIST_BINS)) ? BinW'(HIST_BINS - 1) : sbin_raw[BinW-1:0];
    cbin = (cbin_raw >= SEQ_W'(HIST_BINS)) ? BinW'(HIST_BINS - 1) : cbin_raw[BinW-1:0];
    s_hit = upd && (sgap != '0);
    c_hit = upd && (cgap != '0);

    first_flag_next    = upd ? 1'b1 : ff_eff;
    prev_seq_next      = upd ? in_seq : ps_eff;
    prev_cmd_loss_next = upd ? in_loss : prev_cmd_loss;
    last_cmd_next      = upd ? in_lcmd : last_cmd;

    cnt_rx_next   = (clr ? '0 : cnt_rx)   + CNT_W'(upd);
    cnt_exp_next  = (clr ? '0 : cnt_exp)  + (upd ? CNT_W'(span) : '0);
    cnt_lost_next = (clr ? '0 : cnt_lost) + (upd ? CNT_W'(sgap) : '0);
    cnt_cmd_next  = (clr ? '0 : cnt_cmd)  + (upd ? CNT_W'(cgap) : '0);

    for (int i = 0; i < HIST_BINS; i++) begin
      hist_s_next[i] = (clr ? '0 : hist_s[i]) + CNT_W'(s_hit && (sbin == BinW'(i)));
      hist_c_next[i] = (clr ? '0 : hist_c[i]) + CNT_W'(c_hit && (cbin == BinW'(i)));
    end
  end

  // state registers: reset and config writes re-initialise everything
  always_ff @(posedge clk) begin
    if (rst || cfg_do) begin
      session_known <= rst ? 1'b1 : !cfg_lm_next;
      session_reg   <= rst ? OWN_SESSION_RST : (cfg_lm_next ? '0 : cfg_os_next);
      init_flag     <= 1'b0;
      ack_flag      <= 1'b0;
      first_flag    <= 1'b0;
      prev_seq      <= '0;
      prev_cmd_loss <= '0;
      conn_mask     <= '0;
      last_cmd      <= '0;
      cnt_rx        <= '0;
      cnt_exp       <= '0;
      cnt_lost      <= '0;
      cnt_cmd       <= '0;
      for (int i = 0; i < HIST_BINS; i++) begin
        hist_s[i] <= '0;
        hist_c[i] <= '0;
      end
    end else if (fire) begin
      session_known <= session_known_next;
      session_reg   <= session_reg_next;
      init_flag     <= init_flag_next;
      ack_flag      <= ack_flag_next;
      first_flag    <= first_flag_next;
      prev_seq      <= prev_seq_next;
      prev_cmd_loss <= prev_cmd_loss_next;
      conn_mask     <= conn_mask_next;
      last_cmd      <= last_cmd_next;
      cnt_rx        <= cnt_rx_next;
      cnt_exp       <= cnt_exp_next;
      cnt_lost      <= cnt_lost_next;
      cnt_cmd       <= cnt_cmd_next;
      for (int i = 0; i < HIST_BINS; i++) begin
        hist_s[i] <= hist_s_next[i];
        hist_c[i] <= hist_c_next[i];
      end
    end
  end

  // histogram read-out at bin_select, after this beat's update
  always_comb begin
    sel    = BinW'(in_bin);
    sel_ok = (CNT_W'(in_bin) < CNT_W'(HIST_BINS));
    sel_s  = sel_ok ? hist_s_next[sel] : '1;
    sel_c  = sel_ok ? hist_c_next[sel] : '1;
    out_data = {
      {OUT_PAD_W{1'b0}},
      sel_c,
      sel_s,
      last_cmd_next,
      cnt_cmd_next,
      cnt_lost_next,
      cnt_exp_next,
      cnt_rx_next,
      LINK_W'(conn_mask_next),
      ack_flag_next,
      session_known_next,
      session_known_next ? session_reg_next : {SESSION_W{1'b0}},
      acc
    };
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= out_data;
    end
  end

endmodule

FILE: design/lslm_checker.sv
`timescale 1ns / 1ps
`include "link_session_loss_monitor_defines.svh"

module lslm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [lslm_pkg::OUT_DATA_W-1:0] m_tdata
);
  import lslm_pkg::*;

  // a stalled result beat holds
  `LSLM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

  // input back-pressure only comes from a stalled result
  `LSLM_ASSERT_IMP(a_stall_src, !s_tready, m_tvalid && !m_tready, "input stalled with free result side")

  // an accepted packet always leaves a known session
  `LSLM_ASSERT_IMP(a_acc_known, m_tvalid && m_tdata[O_ACC], m_tdata[O_VALID], "accepted beat without a session")

  // an unlearned session reads as zero
  `LSLM_ASSERT_IMP(a_unknown_zero, m_tvalid && !m_tdata[O_VALID], m_tdata[O_VALID-1:O_SESS] == '0, "unlearned session not zero")

endmodule

bind link_session_loss_monitor lslm_checker u_lslm_checker (.*);
